### rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define MRLR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition in one cycle leads to a consequence in the next.
`define MRLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	`MRLR_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### rtl/mrlr_pkg.sv
// Package for the multi-reader lossy ring: field widths, operation codes,
// parameter defaults and the request/response beat types. No dependencies.
package mrlr_pkg;

	localparam int ID_W   = 2;
	localparam int SIZE_W = 21;
	localparam int TS_W   = 64;
	localparam int KIND_W = 8;
	localparam int SLOT_W = 6;
	localparam int DROP_W = 4;

	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_ATTACH = 2'd2;
	localparam logic [1:0] MODE_DETACH = 2'd3;

	localparam int DEF_RING_DEPTH   = 64;
	localparam int DEF_READER_COUNT = 4;
	localparam int DEF_MAX_PAYLOAD  = 2097151;

	typedef struct packed {
		logic [1:0]             mode;
		logic [ID_W-1:0]        reader_id;
		logic [SIZE_W-1:0]      pkt_size;
		logic signed [TS_W-1:0] pkt_pts;
		logic signed [TS_W-1:0] pkt_dts;
		logic [KIND_W-1:0]      pkt_kind;
	} req_t;

	typedef struct packed {
		logic                   read_valid;
		logic [SLOT_W-1:0]      slot_index;
		logic [SIZE_W-1:0]      out_size;
		logic signed [TS_W-1:0] out_pts;
		logic signed [TS_W-1:0] out_dts;
		logic [KIND_W-1:0]      out_kind;
		logic [DROP_W-1:0]      dropped_mask;
	} rsp_t;

	typedef struct packed {
		logic [SIZE_W-1:0]      size;
		logic signed [TS_W-1:0] pts;
		logic signed [TS_W-1:0] dts;
		logic [KIND_W-1:0]      kind;
	} desc_t;

	typedef struct packed {
		logic              read_hit;
		logic [DROP_W-1:0] drop_mask;
	} rdr_status_t;

endpackage

### rtl/mrlr_readers.sv
// Write pointer, per-reader positions and active flags of the ring.
// Depends on mrlr_pkg; produces the slot addresses and read/drop status per beat.
module mrlr_readers #(
	parameter int RING_DEPTH   = mrlr_pkg::DEF_RING_DEPTH,
	parameter int READER_COUNT = mrlr_pkg::DEF_READER_COUNT,
	localparam int PTR_W       = $clog2(RING_DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [1:0]                mode,
	input  logic [mrlr_pkg::ID_W-1:0] reader_id,
	output logic [PTR_W-1:0]          wr_ptr,
	output logic [PTR_W-1:0]          rd_ptr,
	output mrlr_pkg::rdr_status_t     status
);

	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        wr_after;
	logic [PTR_W-1:0]        pos_q [READER_COUNT];
	logic [READER_COUNT-1:0] active_q;
	logic [READER_COUNT-1:0] sel;
	logic [READER_COUNT-1:0] drop;
	logic [PTR_W-1:0]        rd_pos;
	logic                    rd_act;
	logic                    is_write;
	logic                    is_read;
	logic                    hit;

	assign is_write = (mode == mrlr_pkg::MODE_WRITE);
	assign is_read  = (mode == mrlr_pkg::MODE_READ);
	assign wr_after = next_ptr(wr_ptr_q);

	always_comb begin
		rd_pos = '0;
		for (int i = 0; i < READER_COUNT; i++) begin
			rd_pos = rd_pos | (sel[i] ? pos_q[i] : '0);
		end
	end

	assign rd_act = |(sel & active_q);
	assign hit    = is_read && rd_act && (rd_pos != wr_ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
		end else if (accept && is_write) begin
			wr_ptr_q <= wr_after;
		end
	end

	for (genvar i = 0; i < READER_COUNT; i++) begin : g_reader
		assign sel[i]  = (32'(reader_id) == i);
		assign drop[i] = is_write && active_q[i] && (pos_q[i] == wr_after);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_q[i]    <= '0;
				active_q[i] <= 1'b0;
			end else if (accept) begin
				unique case (mode)
					mrlr_pkg::MODE_WRITE: begin
						if (drop[i]) pos_q[i] <= next_ptr(wr_after);
					end
					mrlr_pkg::MODE_READ: begin
						if (sel[i] && hit) pos_q[i] <= next_ptr(pos_q[i]);
					end
					mrlr_pkg::MODE_ATTACH: begin
						if (sel[i]) begin
							active_q[i] <= 1'b1;
							pos_q[i]    <= wr_ptr_q;
						end
					end
					mrlr_pkg::MODE_DETACH: begin
						if (sel[i]) active_q[i] <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	for (genvar j = 0; j < mrlr_pkg::DROP_W; j++) begin : g_drop
		if (j < READER_COUNT) begin : g_live
			assign status.drop_mask[j] = drop[j];
		end else begin : g_none
			assign status.drop_mask[j] = 1'b0;
		end
	end

	assign status.read_hit = hit;
	assign wr_ptr          = wr_ptr_q;
	assign rd_ptr          = rd_pos;

endmodule

### rtl/multi_reader_lossy_ring_unit.sv
// Multi-reader lossy ring of packet descriptors: one writer, READER_COUNT readers that each
// walk the ring on their own and are pushed ahead (with a drop bit) when the writer laps them.
// Every request beat (write, read, attach, detach) gives exactly one response beat. A beat is
// taken every cycle while the response side keeps up; its response is registered and appears in
// the cycle after it is taken, read through the single registered read port of the memory. A
// response that is not taken holds the request side off. Depends on mrlr_pkg and mrlr_readers.
module multi_reader_lossy_ring_unit #(
	parameter int RING_DEPTH   = mrlr_pkg::DEF_RING_DEPTH,
	parameter int READER_COUNT = mrlr_pkg::DEF_READER_COUNT,
	parameter int MAX_PAYLOAD  = mrlr_pkg::DEF_MAX_PAYLOAD
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mrlr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mrlr_pkg::rsp_t rsp
);

	localparam int PTR_W = $clog2(RING_DEPTH);

	logic                          accept;
	logic [PTR_W-1:0]              wr_ptr;
	logic [PTR_W-1:0]              rd_ptr;
	mrlr_pkg::rdr_status_t         status;
	mrlr_pkg::desc_t               wr_desc;
	mrlr_pkg::desc_t               mem [RING_DEPTH];
	mrlr_pkg::desc_t               rd_q;
	logic                          rsp_valid_q;
	logic                          read_valid_s1;
	logic [mrlr_pkg::SLOT_W-1:0]   slot_s1;
	logic [mrlr_pkg::DROP_W-1:0]   drop_s1;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	mrlr_readers #(
		.RING_DEPTH  (RING_DEPTH),
		.READER_COUNT(READER_COUNT)
	) u_readers (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.mode     (req.mode),
		.reader_id(req.reader_id),
		.wr_ptr   (wr_ptr),
		.rd_ptr   (rd_ptr),
		.status   (status)
	);

	always_comb begin
		wr_desc.size = req.pkt_size;
		if (32'(req.pkt_size) > 32'(MAX_PAYLOAD)) begin
			wr_desc.size = mrlr_pkg::SIZE_W'(MAX_PAYLOAD);
		end
		wr_desc.pts  = req.pkt_pts;
		wr_desc.dts  = req.pkt_dts;
		wr_desc.kind = req.pkt_kind;
	end

	always_ff @(posedge clk) begin
		if (accept && req.mode == mrlr_pkg::MODE_WRITE) begin
			mem[wr_ptr] <= wr_desc;
		end
		if (accept && req.mode == mrlr_pkg::MODE_READ) begin
			rd_q <= mem[rd_ptr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_valid_s1 <= status.read_hit;
			drop_s1       <= status.drop_mask;
			if (req.mode == mrlr_pkg::MODE_WRITE) begin
				slot_s1 <= mrlr_pkg::SLOT_W'(wr_ptr);
			end else if (status.read_hit) begin
				slot_s1 <= mrlr_pkg::SLOT_W'(rd_ptr);
			end else begin
				slot_s1 <= '0;
			end
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign rsp.read_valid    = read_valid_s1;
	assign rsp.slot_index    = slot_s1;
	assign rsp.out_size      = read_valid_s1 ? rd_q.size : '0;
	assign rsp.out_pts       = read_valid_s1 ? rd_q.pts  : '0;
	assign rsp.out_dts       = read_valid_s1 ? rd_q.dts  : '0;
	assign rsp.out_kind      = read_valid_s1 ? rd_q.kind : '0;
	assign rsp.dropped_mask  = drop_s1;

endmodule

### rtl/mrlr_checker.sv
// Port-level checker for multi_reader_lossy_ring_unit, bound to every instance.
// Depends on mrlr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mrlr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input mrlr_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input mrlr_pkg::rsp_t rsp
);

	logic req_beat;
	logic ctl_beat;

	assign req_beat = req_valid && req_ready;
	assign ctl_beat = req_beat &&
		(req.mode == mrlr_pkg::MODE_ATTACH || req.mode == mrlr_pkg::MODE_DETACH);

	`MRLR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")
	`MRLR_ASSERT_NEXT(a_one_cycle, req_beat, rsp_valid, "no response one cycle after request beat")
	`MRLR_ASSERT(a_stall_blocks, rsp_valid && !rsp_ready |-> !req_ready, "request taken over a stalled response")
	`MRLR_ASSERT_NEXT(a_ctl_quiet, ctl_beat, !rsp.read_valid && rsp.dropped_mask == '0 && rsp.slot_index == '0, "attach or detach gave a nonzero response")
	`MRLR_ASSERT_NEXT(a_write_noread, req_beat && req.mode == mrlr_pkg::MODE_WRITE, !rsp.read_valid && rsp.out_size == '0, "write response flagged as read")

endmodule

bind multi_reader_lossy_ring_unit mrlr_checker u_mrlr_checker (.*);

### bench/tb_multi_reader_lossy_ring_unit.sv
// Self-checking bench for multi_reader_lossy_ring_unit: directed and random request beats with
// random idling on both sides, checked field by field against a predictor of the ring.
// Depends on mrlr_pkg and the RTL of the unit.
module tb_multi_reader_lossy_ring_unit;
	import mrlr_pkg::*;

	localparam int DEPTH       = DEF_RING_DEPTH;
	localparam int READERS     = DEF_READER_COUNT;
	localparam int PAYLOAD_MAX = DEF_MAX_PAYLOAD;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	req_t tx_beats [$];
	rsp_t due_rsps [$];
	int   sender_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   error_count = 0;

	logic [SLOT_W-1:0] wr_slot;
	logic [SLOT_W-1:0] rd_slot [READERS];
	logic              rd_live [READERS];
	desc_t             ring [DEPTH];

	multi_reader_lossy_ring_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	function automatic logic [SLOT_W-1:0] ring_advance(input logic [SLOT_W-1:0] p);
		return (p == SLOT_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	task automatic predict_ring(input req_t b, output rsp_t r);
		logic [SLOT_W-1:0] after;
		desc_t d;
		r = '0;
		case (b.mode)
		MODE_WRITE: begin
			d.size = (b.pkt_size > PAYLOAD_MAX) ? SIZE_W'(PAYLOAD_MAX) : b.pkt_size;
			d.pts = b.pkt_pts;
			d.dts = b.pkt_dts;
			d.kind = b.pkt_kind;
			ring[wr_slot] = d;
			after = ring_advance(wr_slot);
			for (int i = 0; i < READERS; i++) begin
				if (rd_live[i] && rd_slot[i] == after) begin
					rd_slot[i] = ring_advance(after);
					if (i < DROP_W)
						r.dropped_mask[i] = 1'b1;
				end
			end
			r.slot_index = wr_slot;
			wr_slot = after;
		end
		MODE_READ: begin
			if (b.reader_id < READERS && rd_live[b.reader_id] &&
			    rd_slot[b.reader_id] != wr_slot) begin
				d = ring[rd_slot[b.reader_id]];
				r.read_valid = 1'b1;
				r.slot_index = rd_slot[b.reader_id];
				r.out_size = d.size;
				r.out_pts = d.pts;
				r.out_dts = d.dts;
				r.out_kind = d.kind;
				rd_slot[b.reader_id] = ring_advance(rd_slot[b.reader_id]);
			end
		end
		MODE_ATTACH: begin
			if (b.reader_id < READERS) begin
				rd_live[b.reader_id] = 1'b1;
				rd_slot[b.reader_id] = wr_slot;
			end
		end
		default: begin
			if (b.reader_id < READERS)
				rd_live[b.reader_id] = 1'b0;
		end
		endcase
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $time, field, got, want);
		error_count++;
	endtask

	task automatic push_beat(input logic [1:0] mode, input logic [ID_W-1:0] id,
			input logic [SIZE_W-1:0] size, input logic [TS_W-1:0] pts,
			input logic [TS_W-1:0] dts, input logic [KIND_W-1:0] kind);
		req_t b;
		b.mode = mode;
		b.reader_id = id;
		b.pkt_size = size;
		b.pkt_pts = pts;
		b.pkt_dts = dts;
		b.pkt_kind = kind;
		tx_beats.push_back(b);
	endtask

	task automatic push_random(input logic [1:0] mode, input logic [ID_W-1:0] id);
		push_beat(mode, id, SIZE_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
			KIND_W'($urandom));
	endtask

	task automatic push_session(input int count);
		int roll;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 44)
				push_random(MODE_WRITE, ID_W'($urandom));
			else if (roll < 86)
				push_random(MODE_READ, ID_W'($urandom));
			else if (roll < 94)
				push_random(MODE_ATTACH, ID_W'($urandom));
			else
				push_random(MODE_DETACH, ID_W'($urandom));
		end
	endtask

	// attach two readers at the same slot, then a burst of writes around the ring depth that can lap them
	task automatic push_lap();
		logic [ID_W-1:0] first;
		logic [ID_W-1:0] second;
		int writes;
		first = ID_W'($urandom);
		second = first ^ ID_W'($urandom_range(1, READERS - 1));
		writes = $urandom_range(DEPTH - 2, DEPTH + 6);
		push_random(MODE_ATTACH, first);
		push_random(MODE_ATTACH, second);
		if ($urandom_range(0, 1))
			push_random(MODE_ATTACH, ID_W'($urandom));
		for (int n = 0; n < writes; n++)
			push_random(MODE_WRITE, ID_W'($urandom));
		for (int n = 0; n < 24; n++) begin
			if ($urandom_range(0, 3) == 0)
				push_random(MODE_WRITE, ID_W'($urandom));
			else
				push_random(MODE_READ, $urandom_range(0, 1) ? first : second);
		end
	endtask

	task automatic drain();
		while (tx_beats.size() != 0 || req_valid || due_rsps.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			if (!req_valid || req_ready) begin
				if (tx_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					req_valid <= 1'b1;
					req <= tx_beats.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (due_rsps.size() == 0) begin
					report_mismatch("response beat with none due", 64'd1, 64'd0);
				end else begin
					want = due_rsps.pop_front();
					if (rsp.read_valid !== want.read_valid)
						report_mismatch("read_valid", rsp.read_valid, want.read_valid);
					if (rsp.slot_index !== want.slot_index)
						report_mismatch("slot_index", rsp.slot_index, want.slot_index);
					if (rsp.out_size !== want.out_size)
						report_mismatch("out_size", rsp.out_size, want.out_size);
					if (rsp.out_pts !== want.out_pts)
						report_mismatch("out_pts", rsp.out_pts, want.out_pts);
					if (rsp.out_dts !== want.out_dts)
						report_mismatch("out_dts", rsp.out_dts, want.out_dts);
					if (rsp.out_kind !== want.out_kind)
						report_mismatch("out_kind", rsp.out_kind, want.out_kind);
					if (rsp.dropped_mask !== want.dropped_mask)
						report_mismatch("dropped_mask", rsp.dropped_mask, want.dropped_mask);
				end
			end
			if (req_valid && req_ready) begin
				predict_ring(req, want);
				due_rsps.push_back(want);
			end
		end
	end

	initial begin
		wr_slot = '0;
		for (int i = 0; i < READERS; i++) begin
			rd_slot[i] = '0;
			rd_live[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_beat(MODE_READ, 0, '0, '0, '0, '0);
		push_beat(MODE_DETACH, 1, '0, '0, '0, '0);
		push_beat(MODE_ATTACH, 0, '0, '0, '0, '0);
		push_beat(MODE_ATTACH, 3, '0, '0, '0, '0);
		push_beat(MODE_READ, 0, '0, '0, '0, '0);
		push_beat(MODE_WRITE, 0, '0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00);
		push_beat(MODE_WRITE, 1, '1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 8'hFF);
		push_beat(MODE_WRITE, 2, 21'h0AAAAA, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'h5A);
		push_beat(MODE_READ, 0, '1, '1, '1, '1);
		push_beat(MODE_READ, 0, '0, '0, '0, '0);
		push_beat(MODE_READ, 0, '0, '0, '0, '0);
		push_beat(MODE_READ, 0, '0, '0, '0, '0);
		push_beat(MODE_READ, 1, '0, '0, '0, '0);
		push_beat(MODE_ATTACH, 0, '0, '0, '0, '0);
		push_beat(MODE_READ, 0, '0, '0, '0, '0);
		push_beat(MODE_READ, 3, '0, '0, '0, '0);
		push_beat(MODE_DETACH, 3, '0, '0, '0, '0);
		push_beat(MODE_READ, 3, '0, '0, '0, '0);
		push_beat(MODE_ATTACH, 1, '0, '0, '0, '0);
		push_beat(MODE_ATTACH, 2, '0, '0, '0, '0);
		push_beat(MODE_WRITE, 3, 21'h155555, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			8'hA5);
		push_beat(MODE_READ, 1, '0, '0, '0, '0);
		push_beat(MODE_READ, 2, '0, '0, '0, '0);
		push_beat(MODE_DETACH, 0, '0, '0, '0, '0);
		push_beat(MODE_DETACH, 1, '0, '0, '0, '0);
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin
				sender_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				sender_idle_pct = 85;
				recv_stall_pct = 0;
			end
			2: begin
				sender_idle_pct = 0;
				recv_stall_pct = 85;
			end
			default: begin
				sender_idle_pct = 34;
				recv_stall_pct = 34;
			end
			endcase
			push_session(30);
			if (p % 2)
				push_lap();
			else
				push_session(40);
			drain();
		end

		repeat (4) @(negedge clk);
		if (error_count == 0)
			$display("tb_multi_reader_lossy_ring_unit: PASS");
		else
			$display("tb_multi_reader_lossy_ring_unit: FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("tb_multi_reader_lossy_ring_unit: FAIL");
		$finish;
	end

endmodule

### multi_reader_lossy_ring_unit.f
+incdir+rtl
rtl/mrlr_pkg.sv
rtl/mrlr_readers.sv
rtl/multi_reader_lossy_ring_unit.sv
rtl/mrlr_checker.sv
bench/tb_multi_reader_lossy_ring_unit.sv
